// ===== src/rtes_pkg.sv =====
// Package for the reservation timeline block: command and status codes, defaults.
// No dependencies.
package rtes_pkg;
	localparam int MAX_SLOTS_DEF = 64;
	localparam int TIME_BITS_DEF = 32;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NEVER    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	localparam logic [1:0] REG_GPU = 2'd0;
	localparam logic [1:0] REG_CPU = 2'd1;
	localparam logic [1:0] REG_MEM = 2'd2;
endpackage

// ===== src/rtes_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rtes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/resource_timeline_earliest_start.sv =====
// Earliest-start search over a reservation table of one server.
// Uses rtes_pkg and rtes_ram.
//
// Insert, clear and unknown commands are answered straight from idle, and no word is
// taken while an answer waits on the output. A query walks candidate starts (release
// time, then every stored end at or after it that beats the best so far) and, for each,
// probe instants (the candidate, then every stored start inside the run); each probe
// sums usage over the table with one table read a cycle from the single entry RAM.
// Probe starts are scanned from the table per candidate and candidates are fetched
// from it per query, with early exit on the first failing probe.
// The table needs no clearing pass; only entries below the fill count are read.
module resource_timeline_earliest_start #(
	parameter int MAX_SLOTS = rtes_pkg::MAX_SLOTS_DEF,
	parameter int TIME_BITS = rtes_pkg::TIME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cmd[1:0], start[33:2], end[65:34], duration[97:66], gpus[105:98],
	// cores[121:106], memory[153:122], zero fill to 160
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], out_start[33:2], out_finish[65:34], zero fill to 72
	output logic [71:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int EW = 2 * TIME_BITS + 56;
	localparam int GS = 8 + CW;
	localparam int CS = 16 + CW;
	localparam int MS = 32 + CW;
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CAND  = 7'b0000010,
		S_PROBE = 7'b0000100,
		S_SUM   = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_NEXTC = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [7:0]  gcap_q;
	logic [15:0] ccap_q;
	logic [31:0] mcap_q;
	logic [CW-1:0] count_q;

	logic [TIME_BITS-1:0] rel_q, dur_q;
	logic [7:0] g_q; logic [15:0] c_q; logic [31:0] m_q;
	logic [TIME_BITS:0] cand_q, best_q, probe_q;
	logic found_q, cand_rel_q;
	logic [CW-1:0] ci_q, pi_q, si_q;
	logic rd_pend_q;
	logic [GS-1:0] ug_q; logic [CS-1:0] uc_q; logic [MS-1:0] um_q;

	logic ovalid_q;
	logic [1:0] ost_q;
	logic [31:0] os_q, of_q;

	// entry RAM
	logic ram_we;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic [TIME_BITS-1:0] e_start, e_end;
	logic [7:0] e_g; logic [15:0] e_c; logic [31:0] e_m;
	assign {e_m, e_c, e_g, e_end, e_start} = ram_rdata;

	logic [1:0] in_cmd;
	logic [TIME_BITS-1:0] in_st, in_en, in_du;
	assign in_cmd = s_tdata[1:0];
	assign in_st  = TIME_BITS'(s_tdata[33:2]);
	assign in_en  = TIME_BITS'(s_tdata[65:34]);
	assign in_du  = TIME_BITS'(s_tdata[97:66]);

	assign s_tready = (state_q == S_IDLE) && !ovalid_q;
	logic acc;
	assign acc = s_tvalid && s_tready;

	assign ram_we    = acc && (in_cmd == rtes_pkg::CMD_INSERT) && (count_q < CW'(MAX_SLOTS));
	assign ram_wdata = {s_tdata[153:122], s_tdata[121:106], s_tdata[105:98], in_en, in_st};

	// read index selects scan source
	logic [CW-1:0] rd_idx;
	always_comb begin
		unique case (state_q)
			S_CAND:  rd_idx = ci_q;
			S_PROBE: rd_idx = pi_q;
			default: rd_idx = si_q;
		endcase
	end
	assign ram_raddr = rd_idx[AW-1:0];

	rtes_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(count_q[AW-1:0]), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic [TIME_BITS:0] fin;
	assign fin = cand_q + {1'b0, dur_q};
	logic e_live, e_hit;
	assign e_live = e_start < e_end;
	assign e_hit  = e_live && ({1'b0, e_start} <= probe_q) && (probe_q < {1'b0, e_end});
	logic [GS-1:0] ug_n; logic [CS-1:0] uc_n; logic [MS-1:0] um_n;
	assign ug_n = ug_q + (e_hit ? GS'(e_g) : '0);
	assign uc_n = uc_q + (e_hit ? CS'(e_c) : '0);
	assign um_n = um_q + (e_hit ? MS'(e_m) : '0);
	logic fits_n;
	assign fits_n = (ug_n <= GS'(gcap_q)) && (uc_n <= CS'(ccap_q)) && (um_n <= MS'(mcap_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gcap_q <= 8'd8; ccap_q <= 16'd64; mcap_q <= 32'd512;
			count_q <= '0;
			ovalid_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rtes_pkg::REG_GPU: gcap_q <= cfg_data[7:0];
					rtes_pkg::REG_CPU: ccap_q <= cfg_data[15:0];
					rtes_pkg::REG_MEM: mcap_q <= cfg_data;
					default: ;
				endcase
			end
			if (ovalid_q && m_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (acc) begin
					os_q <= '0; of_q <= '0;
					rel_q <= in_st; dur_q <= in_du;
					g_q <= s_tdata[105:98]; c_q <= s_tdata[121:106]; m_q <= s_tdata[153:122];
					unique case (in_cmd)
						rtes_pkg::CMD_INSERT: begin
							if (count_q < CW'(MAX_SLOTS)) begin
								count_q <= count_q + 1'b1; ost_q <= rtes_pkg::ST_OK;
							end else ost_q <= rtes_pkg::ST_FULL;
							ovalid_q <= 1'b1;
						end
						rtes_pkg::CMD_CLEAR: begin
							count_q <= '0; ost_q <= rtes_pkg::ST_OK; ovalid_q <= 1'b1;
						end
						rtes_pkg::CMD_QUERY: begin
							if (s_tdata[105:98] > gcap_q || s_tdata[121:106] > ccap_q
							    || s_tdata[153:122] > mcap_q) begin
								ost_q <= rtes_pkg::ST_NEVER; ovalid_q <= 1'b1;
							end else begin
								ost_q <= rtes_pkg::ST_OK;
								cand_q <= {1'b0, in_st}; cand_rel_q <= 1'b1;
								found_q <= 1'b0; ci_q <= '0;
								state_q <= S_NEXTC;
							end
						end
						default: begin
							ost_q <= rtes_pkg::ST_OK; ovalid_q <= 1'b1;
						end
					endcase
				end
				// evaluate cand_q: start probe at the candidate itself
				S_NEXTC: begin
					if (fin <= cand_q) begin
						found_q <= 1'b1; best_q <= cand_q;
						state_q <= cand_rel_q ? S_DONE : S_CAND;
					end else begin
						probe_q <= cand_q; pi_q <= '0;
						si_q <= '0; ug_q <= GS'(g_q); uc_q <= CS'(c_q); um_q <= MS'(m_q);
						rd_pend_q <= 1'b0; state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (!rd_pend_q) begin
						if (si_q == count_q) begin
							// probe fits; advance to next start inside run
							state_q <= S_PROBE;
						end else begin
							rd_pend_q <= 1'b1; si_q <= si_q + 1'b1;
						end
					end else begin
						ug_q <= ug_n; uc_q <= uc_n; um_q <= um_n;
						if (!fits_n) begin
							rd_pend_q <= 1'b0; state_q <= S_CAND;
						end else if (si_q == count_q) begin
							rd_pend_q <= 1'b0; state_q <= S_PROBE;
						end else begin
							si_q <= si_q + 1'b1;
						end
					end
				end
				S_PROBE: begin
					if (!rd_pend_q) begin
						if (pi_q == count_q) begin
							found_q <= 1'b1; best_q <= cand_q;
							state_q <= cand_rel_q ? S_DONE : S_CAND;
						end else begin
							rd_pend_q <= 1'b1; pi_q <= pi_q + 1'b1;
						end
					end else begin
						rd_pend_q <= 1'b0;
						if (e_live && {1'b0, e_start} > cand_q && {1'b0, e_start} < fin) begin
							probe_q <= {1'b0, e_start}; si_q <= '0;
							ug_q <= GS'(g_q); uc_q <= CS'(c_q); um_q <= MS'(m_q);
							state_q <= S_SUM;
						end
					end
				end
				// fetch next candidate end
				S_CAND: begin
					cand_rel_q <= 1'b0;
					if (!rd_pend_q) begin
						if (ci_q == count_q) state_q <= S_DONE;
						else begin
							rd_pend_q <= 1'b1; ci_q <= ci_q + 1'b1;
						end
					end else begin
						rd_pend_q <= 1'b0;
						if ({1'b0, e_end} >= {1'b0, rel_q}
						    && (!found_q || {1'b0, e_end} < best_q)) begin
							cand_q <= {1'b0, e_end}; state_q <= S_NEXTC;
						end
					end
				end
				S_DONE: begin
					ovalid_q <= 1'b1;
					if (!found_q) ost_q <= rtes_pkg::ST_NEVER;
					else if (best_q + {1'b0, dur_q} > {1'b0, TMAX}) begin
						ost_q <= rtes_pkg::ST_OVERFLOW;
						os_q <= 32'(best_q); of_q <= 32'(TMAX);
					end else begin
						os_q <= 32'(best_q); of_q <= 32'(best_q + {1'b0, dur_q});
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {6'd0, of_q, os_q, ost_q};

	a_fill: assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_SLOTS))
		else $error("fill count beyond depth");
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("ready during search");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> ovalid_q)
		else $error("search finished without result");
endmodule

// ===== bench/resource_timeline_earliest_start_tb.sv =====
// Self-checking bench for resource_timeline_earliest_start: streams insert, query, clear
// and unused command words, predicts each answer and compares it on the output stream.
// Depends on rtes_pkg and the block itself.
module resource_timeline_earliest_start_tb;
	import rtes_pkg::*;

	localparam int SLOTS = MAX_SLOTS_DEF;
	localparam logic [63:0] TMAX = 64'hFFFF_FFFF;
	localparam int CYCLE_LIMIT = 5_000_000;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] st;
		logic [31:0] en;
		logic [31:0] du;
		logic [7:0]  g;
		logic [15:0] c;
		logic [31:0] m;
	} job_word_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] start;
		logic [31:0] finish;
	} answer_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = REG_GPU;
	logic [31:0]  cfg_data = '0;

	resource_timeline_earliest_start dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor's copy of the table and capacities
	logic [63:0] tab_st[SLOTS];
	logic [63:0] tab_en[SLOTS];
	logic [63:0] tab_g[SLOTS];
	logic [63:0] tab_c[SLOTS];
	logic [63:0] tab_m[SLOTS];
	int          tab_n = 0;
	logic [63:0] cap_g = 8, cap_c = 64, cap_m = 512;

	job_word_t pending_jobs[$];
	answer_t   expected_answers[$];
	int        errors = 0;
	int        cycles = 0;
	int        gen_n = 0;

	initial forever #5 clk = ~clk;

	function automatic bit fits_at(logic [63:0] t, logic [63:0] g, logic [63:0] c,
			logic [63:0] m);
		logic [63:0] ug, uc, um;
		ug = g; uc = c; um = m;
		for (int i = 0; i < tab_n; i++)
			if (tab_st[i] < tab_en[i] && tab_st[i] <= t && t < tab_en[i]) begin
				ug += tab_g[i]; uc += tab_c[i]; um += tab_m[i];
			end
		return ug <= cap_g && uc <= cap_c && um <= cap_m;
	endfunction

	// usage only rises at entry starts, so probing those covers the run
	function automatic bit fits_span(logic [63:0] s, logic [63:0] f, logic [63:0] g,
			logic [63:0] c, logic [63:0] m);
		if (f <= s) return 1'b1;
		if (!fits_at(s, g, c, m)) return 1'b0;
		for (int i = 0; i < tab_n; i++)
			if (tab_st[i] < tab_en[i] && tab_st[i] > s && tab_st[i] < f
					&& !fits_at(tab_st[i], g, c, m))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic answer_t earliest_start(job_word_t j);
		answer_t     a;
		bit          found;
		logic [63:0] best, e, du, st, g, c, m;
		a = '{ST_OK, 32'd0, 32'd0};
		found = 1'b0;
		best = '0;
		du = {32'd0, j.du};
		st = {32'd0, j.st};
		g = {56'd0, j.g}; c = {48'd0, j.c}; m = {32'd0, j.m};
		case (j.cmd)
			CMD_INSERT: begin
				if (tab_n >= SLOTS) a.status = ST_FULL;
				else begin
					tab_st[tab_n] = st; tab_en[tab_n] = {32'd0, j.en};
					tab_g[tab_n] = g; tab_c[tab_n] = c; tab_m[tab_n] = m;
					tab_n++;
				end
			end
			CMD_CLEAR: tab_n = 0;
			CMD_QUERY: begin
				if (g > cap_g || c > cap_c || m > cap_m) a.status = ST_NEVER;
				else begin
					if (fits_span(st, st + du, g, c, m)) begin
						found = 1'b1; best = st;
					end else
						for (int i = 0; i < tab_n; i++) begin
							e = tab_en[i];
							if (e >= st && (!found || e < best)
									&& fits_span(e, e + du, g, c, m)) begin
								found = 1'b1; best = e;
							end
						end
					if (!found) a.status = ST_NEVER;
					else if (best + du > TMAX) begin
						a.status = ST_OVERFLOW; a.start = best[31:0]; a.finish = '1;
					end else begin
						a.start = best[31:0]; a.finish = best[31:0] + j.du;
					end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic add_job(cmd_t cmd, logic [31:0] st, logic [31:0] en, logic [31:0] du,
			logic [7:0] g, logic [15:0] c, logic [31:0] m);
		job_word_t w;
		w = '{cmd, st, en, du, g, c, m};
		pending_jobs.insert(pending_jobs.size(), w);
	endtask

	task automatic wait_idle();
		while (pending_jobs.size() != 0 || expected_answers.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one register per edge, enable dropped on the edge after the last
	task automatic set_caps(logic [7:0] g, logic [15:0] c, logic [31:0] m);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= REG_GPU; cfg_data <= {24'd0, g};
		@(posedge clk);
		cfg_index <= REG_CPU; cfg_data <= {16'd0, c};
		@(posedge clk);
		cfg_index <= REG_MEM; cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_g = {56'd0, g}; cap_c = {48'd0, c}; cap_m = {32'd0, m};
	endtask

	function automatic logic [31:0] rnd_time();
		if ($urandom_range(15) == 0) return $urandom;
		return $urandom_range(300);
	endfunction

	task automatic random_jobs(int count);
		int   k;
		cmd_t cmd;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			cmd = k < 45 ? CMD_INSERT : k < 87 ? CMD_QUERY : k < 94 ? CMD_CLEAR : CMD_NONE;
			if (cmd == CMD_INSERT && gen_n >= 12) cmd = CMD_CLEAR;
			if (cmd == CMD_INSERT) gen_n++;
			if (cmd == CMD_CLEAR) gen_n = 0;
			if (cmd == CMD_QUERY && $urandom_range(9) == 0)
				add_job(cmd, 32'hFFFF_FF00 + $urandom_range(255), $urandom,
					$urandom_range(600), 8'($urandom_range(32'(cap_g))),
					16'($urandom_range(32'(cap_c))), 0);
			else if ($urandom_range(11) == 0)
				add_job(cmd, $urandom, $urandom, $urandom, 8'($urandom), 16'($urandom),
					$urandom);
			else begin
				logic [31:0] st;
				st = rnd_time();
				add_job(cmd, st, st + $urandom_range(120) - 10, $urandom_range(80),
					8'($urandom_range(32'(cap_g > 2 ? cap_g / 2 + 1 : 2))),
					16'($urandom_range(32'(cap_c > 4 ? cap_c / 2 + 1 : 4))),
					$urandom_range(32'(cap_m > 8 ? cap_m / 2 + 1 : 8)));
			end
		end
	endtask

	// sender: bursts of random length separated by random gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		job_word_t j;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_jobs.size() != 0) begin
				j = pending_jobs.pop_front();
				s_tdata <= {6'd0, j.m, j.c, j.g, j.du, j.en, j.st, j.cmd};
				s_tvalid <= 1'b1;
				expected_answers.insert(expected_answers.size(), earliest_start(j));
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(12, 1);
					gap_left <= $urandom_range(3) == 0 ? 0 : $urandom_range(6);
				end else
					burst_left <= burst_left - 1;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// receiver: stall mode is re-drawn at random from four ready patterns
	int rx_mode = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 48 == 0) rx_mode <= $urandom_range(3);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= cycles[0];
			2: m_tready <= 1'($urandom_range(1));
			default: m_tready <= $urandom_range(7) == 0;
		endcase
		if (m_tvalid && m_tready) begin
			answer_t want;
			if (expected_answers.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %h", $time, m_tdata);
			end else begin
				want = expected_answers.pop_front();
				if (m_tdata[1:0] !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						m_tdata[1:0]);
				end
				if (m_tdata[33:2] !== want.start) begin
					errors++;
					$display("%0t: out_start expected %h actual %h", $time, want.start,
						m_tdata[33:2]);
				end
				if (m_tdata[65:34] !== want.finish) begin
					errors++;
					$display("%0t: out_finish expected %h actual %h", $time, want.finish,
						m_tdata[65:34]);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		set_caps(8'd4, 16'd16, 32'd100);

		// directed: overlaps, degenerate entries, never fits, overflow, odd commands
		add_job(CMD_QUERY, 32'd5, 0, 32'd10, 8'd4, 16'd16, 32'd100);
		add_job(CMD_INSERT, 32'd10, 32'd20, 0, 8'd2, 16'd4, 32'd10);
		add_job(CMD_INSERT, 32'd15, 32'd30, 0, 8'd2, 16'd4, 32'd10);
		add_job(CMD_INSERT, 32'd50, 32'd40, 0, 8'd4, 16'd16, 32'd100);
		add_job(CMD_INSERT, 32'd60, 32'd60, 0, 8'd4, 16'd16, 32'd100);
		add_job(CMD_QUERY, 32'd0, 0, 32'd12, 8'd1, 16'd1, 32'd1);
		add_job(CMD_QUERY, 32'd0, 0, 32'd12, 8'd3, 16'd1, 32'd1);
		add_job(CMD_QUERY, 32'd16, 0, 32'd0, 8'd4, 16'd16, 32'd100);
		add_job(CMD_QUERY, 32'd16, 0, 32'd0, 8'd5, 16'd0, 32'd0);
		add_job(CMD_QUERY, 32'd0, 0, 32'd1, 8'd0, 16'd17, 32'd0);
		add_job(CMD_QUERY, 32'd0, 0, 32'd1, 8'd0, 16'd0, 32'd101);
		add_job(CMD_QUERY, 32'd42, 32'hFFFF_FFFF, 32'd5, 8'd4, 16'd0, 32'd0);
		add_job(CMD_QUERY, 32'hFFFF_FFF0, 0, 32'h100, 8'd1, 16'd1, 32'd1);
		add_job(CMD_QUERY, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 8'd0, 16'd0, 32'd0);
		add_job(CMD_NONE, '1, '1, '1, '1, '1, '1);
		add_job(CMD_CLEAR, '1, '1, '1, '1, '1, '1);
		add_job(CMD_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0, 8'd1, 16'd1, 32'd1);
		add_job(CMD_QUERY, 32'hFFFF_FFF8, 0, 32'd4, 8'd4, 16'd16, 32'd100);
		add_job(CMD_QUERY, 32'hFFFF_FFF8, 0, 32'd40, 8'd4, 16'd16, 32'd100);
		add_job(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		wait_idle();

		set_caps(8'd0, 16'd0, 32'd0);
		add_job(CMD_INSERT, 32'd0, 32'd9, 0, 8'd0, 16'd0, 32'd0);
		add_job(CMD_QUERY, 32'd3, 0, 32'd5, 8'd0, 16'd0, 32'd0);
		add_job(CMD_QUERY, 32'd3, 0, 32'd5, 8'd1, 16'd0, 32'd0);
		add_job(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		wait_idle();

		// fill the table and push past the end
		set_caps(8'd255, 16'hFFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < SLOTS + 2; i++)
			add_job(CMD_INSERT, i * 3, i * 3 + $urandom_range(20), 0,
				8'($urandom_range(10)), 16'($urandom_range(2000)), $urandom);
		add_job(CMD_QUERY, 32'd30, 0, 32'd0, 8'd255, 16'hFFFF, 32'hFFFF_FFFF);
		add_job(CMD_QUERY, 32'd10, 0, 32'd100, 8'd0, 16'd0, 32'd0);
		add_job(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		wait_idle();

		gen_n = 0;
		set_caps(8'd6, 16'd40, 32'd1000);
		random_jobs(20);
		add_job(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		wait_idle();
		gen_n = 0;
		set_caps(8'd255, 16'hFFFF, 32'hFFFF_FFFF);
		random_jobs(10);
		add_job(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		wait_idle();
		gen_n = 0;
		set_caps(8'd3, 16'd5, 32'd20);
		random_jobs(15);
		wait_idle();

		repeat (50) @(posedge clk);
		if (errors == 0 && expected_answers.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
